// ===== sv/kca_pkg.sv =====
package kca_pkg;

    localparam int EXP_W  = 11;
    localparam int FRAC_W = 52;
    localparam int DBL_W  = 64;

    localparam logic [DBL_W-1:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [DBL_W-1:0] POS_ZERO  = 64'h0000_0000_0000_0000;
    localparam logic [EXP_W-1:0] EXP_MAX   = '1;

    typedef struct packed {
        logic [DBL_W-1:0] value_bits;
        logic             clear_first;
        logic             last_of_run;
    } item_t;

    typedef struct packed {
        logic [DBL_W-1:0] sum_bits;
        logic [DBL_W-1:0] max_error_bits;
        logic [DBL_W-1:0] min_error_bits;
        logic             end_of_run;
    } result_t;

    function automatic logic is_nan(input logic [DBL_W-1:0] x);
        return (x[62:52] == EXP_MAX) && (x[51:0] != '0);
    endfunction

    // x <= y as an IEEE compare; any NaN makes it false
    function automatic logic fp_le(input logic [DBL_W-1:0] x, input logic [DBL_W-1:0] y);
        logic res;
        res = 1'b0;
        if (is_nan(x) || is_nan(y))
            res = 1'b0;
        else if (x[62:0] == '0 && y[62:0] == '0)
            res = 1'b1;
        else if (x[63] != y[63])
            res = x[63];
        else if (!x[63])
            res = (x[62:0] <= y[62:0]);
        else
            res = (x[62:0] >= y[62:0]);
        return res;
    endfunction

endpackage

// ===== sv/kca_ifs.sv =====
interface kca_item_if;
    import kca_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kca_result_if;
    import kca_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/kca_fadd.sv =====
module kca_fadd
    import kca_pkg::*;
(
    input  logic [DBL_W-1:0] a,
    input  logic [DBL_W-1:0] b,
    input  logic             sub,
    output logic [DBL_W-1:0] r
);

    localparam int WW = 56;   // 53 mantissa bits + guard, round, sticky

    function automatic logic [5:0] lzc(input logic [WW-1:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'(WW);
        found = 1'b0;
        for (int i = WW-1; i >= 0; i--) begin
            if (v[i] && !found)
            begin
                n = 6'(WW-1-i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    logic              sb_eff, swap, sx, sy, eff_sub;
    logic [DBL_W-1:0]  bx;
    logic [DBL_W-1:0]  x, y;
    logic [EXP_W-1:0]  ex, ey;
    logic [52:0]       mx, my;
    logic [11:0]       dexp;
    logic [5:0]        sh;
    logic [2*WW-1:0]   ywide;
    logic [WW-1:0]     wa, wb;
    logic [WW:0]       s;
    logic [5:0]        lz, lsh;
    logic [WW-1:0]     n;
    logic [11:0]       e_n;
    logic              rnd_up;
    logic [53:0]       mr;
    logic [11:0]       ef;
    logic [51:0]       frac;

    always_comb
    begin
        sb_eff = b[63] ^ sub;
        bx     = {sb_eff, b[62:0]};
        swap   = (bx[62:0] > a[62:0]);
        x      = swap ? bx : a;
        y      = swap ? a : bx;
        sx     = x[63];
        sy     = y[63];
        eff_sub = sx ^ sy;
        ex     = (x[62:52] == '0) ? 11'd1 : x[62:52];
        ey     = (y[62:52] == '0) ? 11'd1 : y[62:52];
        mx     = {(x[62:52] != '0), x[51:0]};
        my     = {(y[62:52] != '0), y[51:0]};
        dexp   = {1'b0, ex} - {1'b0, ey};
        sh     = (dexp > 12'd63) ? 6'd63 : dexp[5:0];
        ywide  = {my, 3'b000, {WW{1'b0}}} >> sh;
        wa     = {mx, 3'b000};
        wb     = ywide[2*WW-1:WW] | {{(WW-1){1'b0}}, |ywide[WW-1:0]};
        s      = eff_sub ? ({1'b0, wa} - {1'b0, wb}) : ({1'b0, wa} + {1'b0, wb});

        lz  = lzc(s[WW-1:0]);
        lsh = ({6'd0, lz} > ({1'b0, ex} - 12'd1)) ? 6'(ex - 11'd1) : lz;
        if (s[WW])
        begin
            n   = s[WW:1] | {{(WW-1){1'b0}}, s[0]};
            e_n = {1'b0, ex} + 12'd1;
        end
        else
        begin
            n   = s[WW-1:0] << lsh;
            e_n = {1'b0, ex} - {6'd0, lsh};
        end

        rnd_up = n[2] & (n[1] | n[0] | n[3]);
        mr     = {1'b0, n[WW-1:3]} + {53'd0, rnd_up};
        if (mr[53])
            ef = e_n + 12'd1;
        else if (mr[52])
            ef = e_n;
        else
            ef = '0;
        frac = mr[53] ? mr[52:1] : mr[51:0];

        // specials first, then exact zero, overflow, ordinary result
        if (is_nan(a) || is_nan(b))
            r = CANON_NAN;
        else if (a[62:52] == EXP_MAX && bx[62:52] == EXP_MAX)
            r = (a[63] != sb_eff) ? CANON_NAN : {a[63], EXP_MAX, 52'd0};
        else if (a[62:52] == EXP_MAX)
            r = a;
        else if (bx[62:52] == EXP_MAX)
            r = bx;
        else if (mr == '0)
            r = {sx & sy, 63'd0};
        else if (ef >= 12'(EXP_MAX))
            r = {sx, EXP_MAX, 52'd0};
        else
            r = {sx, ef[10:0], frac};
    end

endmodule

// ===== sv/kahan_compensated_accumulator_top.sv =====
// Kahan-compensated double accumulator.
// An accepted transaction's result appears on the output register in the next cycle.
// Throughput: 1 transaction per cycle unless the result side stalls; the four double
// add units form the sum/compensation chain, closed through the state registers.
// Reset: rst_n (async, active low) zeroes sum, compensation and both extremes
// to +0.0 and empties the output register.
module kahan_compensated_accumulator_top
    import kca_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    kca_item_if.sink      item,
    kca_result_if.source  result
);

    logic [DBL_W-1:0] sum_reg,  sum_next;
    logic [DBL_W-1:0] comp_reg, comp_next;
    logic [DBL_W-1:0] max_reg,  max_next;
    logic [DBL_W-1:0] min_reg,  min_next;
    logic             out_valid_reg;
    result_t          out_data_reg;

    logic [DBL_W-1:0] sum_cur, comp_cur, max_cur, min_cur;
    logic [DBL_W-1:0] comp_in, diff;
    logic             accept;

    // Output register frees up in the same cycle it is drained.
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // Clear applies before this value is folded in.
    always_comb
    begin
        sum_cur  = item.data.clear_first ? POS_ZERO : sum_reg;
        comp_cur = item.data.clear_first ? POS_ZERO : comp_reg;
        max_cur  = item.data.clear_first ? POS_ZERO : max_reg;
        min_cur  = item.data.clear_first ? POS_ZERO : min_reg;
    end

    // y = value - c ; t = sum + y ; c' = (t - sum) - y
    kca_fadd u_sub_comp (.a(item.data.value_bits), .b(comp_cur), .sub(1'b1), .r(comp_in));
    kca_fadd u_add_sum  (.a(sum_cur),  .b(comp_in),  .sub(1'b0), .r(sum_next));
    kca_fadd u_sub_old  (.a(sum_next), .b(sum_cur),  .sub(1'b1), .r(diff));
    kca_fadd u_sub_y    (.a(diff),     .b(comp_in),  .sub(1'b1), .r(comp_next));

    // Keep the old extreme whenever a NaN is involved; ties take the new value.
    always_comb
    begin
        max_next = fp_le(max_cur, comp_next) ? comp_next : max_cur;
        min_next = fp_le(comp_next, min_cur) ? comp_next : min_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= POS_ZERO;
            comp_reg <= POS_ZERO;
            max_reg  <= POS_ZERO;
            min_reg  <= POS_ZERO;
        end
        else if (accept)
        begin
            sum_reg  <= sum_next;
            comp_reg <= comp_next;
            max_reg  <= max_next;
            min_reg  <= min_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Payload register: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.sum_bits       <= sum_next;
            out_data_reg.max_error_bits <= max_next;
            out_data_reg.min_error_bits <= min_next;
            out_data_reg.end_of_run     <= item.data.last_of_run;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule
